[rtl/pdmix_pkg.sv]
// shared types and constants for the pitch pd motor duty mixer
package pdmix_pkg;

  localparam int ANGLE_W  = 16;
  localparam int CMD_W    = 12;
  localparam int GAIN_W   = 16;
  localparam int SPD_W    = 10;
  localparam int DUTY_W   = 12;
  localparam int FRAC_W   = 8;
  localparam int SPEED_W  = SPD_W + FRAC_W;   // clamped speed, 8 fraction bits
  localparam int SLOPE_W  = 17;               // q1.16
  localparam int MPROD_W  = SLOPE_W + SPEED_W;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic [SLOPE_W-1:0] SLOPE_FRONT = 17'd63096;
  localparam logic [SLOPE_W-1:0] SLOPE_BACK  = 17'd65097;
  localparam logic [SLOPE_W-1:0] SLOPE_LEFT  = 17'd65198;
  localparam logic [SLOPE_W-1:0] SLOPE_RIGHT = 17'd65100;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd30196;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd3020;
  localparam logic [SPD_W-1:0]  HOVER_RST      = 10'd471;
  localparam logic [SPD_W-1:0]  SPEED_MAX_RST  = 10'd681;
  localparam logic [DUTY_W-1:0] FRONT_OFS_RST  = 12'd827;
  localparam logic [DUTY_W-1:0] BACK_OFS_RST   = 12'd891;
  localparam logic [DUTY_W-1:0] LEFT_OFS_RST   = 12'd886;
  localparam logic [DUTY_W-1:0] RIGHT_OFS_RST  = 12'd890;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT = 12'd4095;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_DERIV_GAIN   = 3'd1,
    CFG_HOVER_SPEED  = 3'd2,
    CFG_SPEED_MAX    = 3'd3,
    CFG_FRONT_OFFSET = 3'd4,
    CFG_BACK_OFFSET  = 3'd5,
    CFG_LEFT_OFFSET  = 3'd6,
    CFG_RIGHT_OFFSET = 3'd7
  } cfg_idx_t;

  localparam int PIPE_DEPTH = 4;

endpackage

[rtl/pitch_pd_motor_duty_mixer.sv]
// pitch pd correction, motor mixing and speed to pwm duty mapping
// throughput: one word per cycle; four register stages (gain multiply, mix and clamp,
//   slope multiply, round and offset) each hold one word and move on independently
// stalls: a stage holds its word while the stage after it is full and not moving
// reset: synchronous rst empties the pipeline and loads the register defaults
module pitch_pd_motor_duty_mixer
  import pdmix_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CFG_DW-1:0]       cfg_data,
  // input stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // pitch_angle[15:0], pitch_rate[31:16], left_speed[43:32], right_speed[55:44]
  input  logic [IN_TDATA_W-1:0]   s_tdata,
  // output stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // front_duty[11:0], back_duty[23:12], left_duty[35:24], right_duty[47:36]
  output logic [OUT_TDATA_W-1:0]  m_tdata
);

  localparam int GPROD_W = GAIN_W + ANGLE_W + 1;  // signed gain product
  localparam int PSUM_W  = GPROD_W + 1;
  localparam int NEG_W   = PSUM_W + 1;
  localparam int F_W     = NEG_W - 12;
  localparam int MIX_W   = 24;

  // configuration registers
  logic [GAIN_W-1:0] prop_gain, deriv_gain;
  logic [SPD_W-1:0]  hover_speed, speed_max;
  logic [DUTY_W-1:0] front_offset, back_offset, left_offset, right_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= PROP_GAIN_RST;
      deriv_gain   <= DERIV_GAIN_RST;
      hover_speed  <= HOVER_RST;
      speed_max    <= SPEED_MAX_RST;
      front_offset <= FRONT_OFS_RST;
      back_offset  <= BACK_OFS_RST;
      left_offset  <= LEFT_OFS_RST;
      right_offset <= RIGHT_OFS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PROP_GAIN:    prop_gain    <= cfg_data;
        CFG_DERIV_GAIN:   deriv_gain   <= cfg_data;
        CFG_HOVER_SPEED:  hover_speed  <= cfg_data[SPD_W-1:0];
        CFG_SPEED_MAX:    speed_max    <= cfg_data[SPD_W-1:0];
        CFG_FRONT_OFFSET: front_offset <= cfg_data[DUTY_W-1:0];
        CFG_BACK_OFFSET:  back_offset  <= cfg_data[DUTY_W-1:0];
        CFG_LEFT_OFFSET:  left_offset  <= cfg_data[DUTY_W-1:0];
        CFG_RIGHT_OFFSET: right_offset <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when it is empty or its word moves on
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4 = !v4 || m_tready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // stage 1: gain products
  logic signed [ANGLE_W-1:0] in_angle, in_rate;
  logic signed [GPROD_W-1:0] prod_p_next, prod_d_next;
  logic signed [GPROD_W-1:0] prod_p, prod_d;
  logic signed [CMD_W-1:0]   cmd_l1, cmd_r1;

  assign in_angle = s_tdata[15:0];
  assign in_rate  = s_tdata[31:16];

  always_comb begin
    prod_p_next = GPROD_W'($signed({1'b0, prop_gain})) * GPROD_W'(in_angle);
    prod_d_next = GPROD_W'($signed({1'b0, deriv_gain})) * GPROD_W'(in_rate);
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      prod_p <= prod_p_next;
      prod_d <= prod_d_next;
      cmd_l1 <= s_tdata[43:32];
      cmd_r1 <= s_tdata[55:44];
    end
  end

  // stage 2: pd correction, front/back mix, clamp to [0, speed_max]
  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic signed [MIX_W-1:0] s,
    input logic        [SPEED_W-1:0] top
  );
    logic [SPEED_W-1:0] res;
    if (s < 0)
      res = '0;
    else if (s > $signed({{(MIX_W-SPEED_W){1'b0}}, top}))
      res = top;
    else
      res = s[SPEED_W-1:0];
    return res;
  endfunction

  logic signed [PSUM_W-1:0] psum;
  logic signed [NEG_W-1:0]  neg_rnd;
  logic signed [F_W-1:0]    corr;
  logic signed [MIX_W-1:0]  hover_fx, front_mix, back_mix, left_mix, right_mix;
  logic        [SPEED_W-1:0] top_fx;
  logic [SPEED_W-1:0] spd_f, spd_b, spd_l, spd_r;

  always_comb begin
    psum      = PSUM_W'(prod_p) + PSUM_W'(prod_d);
    // negate and round half up to 8 fraction bits
    neg_rnd   = NEG_W'(2048) - NEG_W'(psum);
    corr      = F_W'(neg_rnd >>> 12);
    hover_fx  = $signed({{(MIX_W-SPEED_W){1'b0}}, hover_speed, {FRAC_W{1'b0}}});
    top_fx    = {speed_max, {FRAC_W{1'b0}}};
    front_mix = hover_fx + MIX_W'(corr);
    back_mix  = hover_fx - MIX_W'(corr);
    left_mix  = MIX_W'($signed({cmd_l1, {FRAC_W{1'b0}}}));
    right_mix = MIX_W'($signed({cmd_r1, {FRAC_W{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      spd_f <= clamp_speed(front_mix, top_fx);
      spd_b <= clamp_speed(back_mix, top_fx);
      spd_l <= clamp_speed(left_mix, top_fx);
      spd_r <= clamp_speed(right_mix, top_fx);
    end
  end

  // stage 3: slope products
  logic [MPROD_W-1:0] mp_f, mp_b, mp_l, mp_r;

  always_ff @(posedge clk) begin
    if (r3) begin
      mp_f <= MPROD_W'(SLOPE_FRONT) * MPROD_W'(spd_f);
      mp_b <= MPROD_W'(SLOPE_BACK)  * MPROD_W'(spd_b);
      mp_l <= MPROD_W'(SLOPE_LEFT)  * MPROD_W'(spd_l);
      mp_r <= MPROD_W'(SLOPE_RIGHT) * MPROD_W'(spd_r);
    end
  end

  // stage 4: round, add offset, saturate
  function automatic logic [DUTY_W-1:0] to_duty(
    input logic [MPROD_W-1:0] prod,
    input logic [DUTY_W-1:0]  ofs
  );
    logic [MPROD_W:0]   rnd;
    logic [DUTY_W:0]    sum;
    rnd = {1'b0, prod} + (MPROD_W+1)'(24'h800000);
    sum = (DUTY_W+1)'(rnd[MPROD_W:24]) + {1'b0, ofs};
    return sum[DUTY_W] ? DUTY_LIMIT : sum[DUTY_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (r4) begin
      m_tdata <= {to_duty(mp_r, right_offset), to_duty(mp_l, left_offset),
                  to_duty(mp_b, back_offset),  to_duty(mp_f, front_offset)};
    end
  end

  assign m_tvalid = v4;

endmodule

[rtl/pdmix_checker.sv]
// port-level checks for the pitch pd motor duty mixer
module pdmix_checker
  import pdmix_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // words accepted and not yet delivered
  logic [2:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    in_flight == 3'd0 |-> !m_tvalid)
    else $error("output word with nothing in flight");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_flight == 3'(PIPE_DEPTH))
    else $error("input stalled while pipeline has room");

endmodule

bind pitch_pd_motor_duty_mixer pdmix_checker u_pdmix_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tb_pitch_pd_motor_duty_mixer.sv]
// testbench for the pitch pd motor duty mixer: directed and random samples against a predictor
module tb_pitch_pd_motor_duty_mixer;
  import pdmix_pkg::*;

  localparam longint FRONT_SLOPE = 63096;
  localparam longint BACK_SLOPE  = 65097;
  localparam longint LEFT_SLOPE  = 65198;
  localparam longint RIGHT_SLOPE = 65100;
  localparam longint MAX_DUTY    = 4095;
  localparam int     MAX_REPORTS = 10;
  localparam int     RANDOM_PHASES = 6;
  localparam int     PHASE_SAMPLES = 75;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] rate;
    logic signed [11:0] lspd;
    logic signed [11:0] rspd;
  } imu_sample_t;

  typedef struct {
    logic [11:0] front;
    logic [11:0] back;
    logic [11:0] left;
    logic [11:0] right;
  } duty_set_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_DW-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  // pitch_angle, pitch_rate, left_speed, right_speed
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  // front_duty, back_duty, left_duty, right_duty
  logic [OUT_TDATA_W-1:0] m_tdata;

  // register copies used by the predictor
  logic [15:0] kp_reg;
  logic [15:0] kd_reg;
  logic [9:0]  hover_reg;
  logic [9:0]  smax_reg;
  logic [11:0] front_ofs;
  logic [11:0] back_ofs;
  logic [11:0] left_ofs;
  logic [11:0] right_ofs;

  duty_set_t duty_q[$];
  int  samples_sent;
  int  duties_seen;
  int  mismatches;
  int  cfg_phases;
  bit  idle_on;

  pitch_pd_motor_duty_mixer uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [11:0] speed_to_duty(longint spd, longint slope,
                                                logic [11:0] ofs);
    longint top;
    longint acc;
    longint d;
    top = longint'(smax_reg) * 256;
    if (spd < 0) spd = 0;
    if (spd > top) spd = top;
    acc = slope * spd + (longint'(ofs) << 24) + (longint'(1) << 23);
    d = acc >>> 24;
    if (d > MAX_DUTY) d = MAX_DUTY;
    return d[11:0];
  endfunction

  function automatic duty_set_t mix_duties(imu_sample_t smp);
    duty_set_t res;
    longint p;
    longint corr;
    longint hov;
    p = longint'(kp_reg) * longint'(smp.angle) + longint'(kd_reg) * longint'(smp.rate);
    // correction rounded to 8 fraction bits, half toward plus infinity
    corr = (2048 - p) >>> 12;
    hov = longint'(hover_reg) * 256;
    res.front = speed_to_duty(hov + corr, FRONT_SLOPE, front_ofs);
    res.back  = speed_to_duty(hov - corr, BACK_SLOPE, back_ofs);
    res.left  = speed_to_duty(longint'(smp.lspd) * 256, LEFT_SLOPE, left_ofs);
    res.right = speed_to_duty(longint'(smp.rspd) * 256, RIGHT_SLOPE, right_ofs);
    return res;
  endfunction

  task automatic report_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("word %0d: %s expected %0d got %0d", duties_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : duty_check
    duty_set_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word %0d: unexpected output %h", duties_seen, m_tdata);
      end else begin
        want = duty_q.pop_front();
        report_field("front_duty", want.front, m_tdata[11:0]);
        report_field("back_duty", want.back, m_tdata[23:12]);
        report_field("left_duty", want.left, m_tdata[35:24]);
        report_field("right_duty", want.right, m_tdata[47:36]);
      end
      duties_seen++;
    end
  end

  // receiver side: random stall before each word while idle_on is set
  initial begin : duty_sink
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(8, 0) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_sample(logic signed [15:0] angle, logic signed [15:0] rate,
                             logic signed [11:0] lspd, logic signed [11:0] rspd);
    imu_sample_t smp;
    int gap;
    smp.angle = angle;
    smp.rate  = rate;
    smp.lspd  = lspd;
    smp.rspd  = rspd;
    gap = idle_on ? $urandom_range(8, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rspd, lspd, rate, angle};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    duty_q.push_back(mix_duties(smp));
    samples_sent++;
  endtask

  // let every word in flight come out before touching the registers
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= 16'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROP_GAIN:    kp_reg    = 16'(val);
      CFG_DERIV_GAIN:   kd_reg    = 16'(val);
      CFG_HOVER_SPEED:  hover_reg = 10'(val);
      CFG_SPEED_MAX:    smax_reg  = 10'(val);
      CFG_FRONT_OFFSET: front_ofs = 12'(val);
      CFG_BACK_OFFSET:  back_ofs  = 12'(val);
      CFG_LEFT_OFFSET:  left_ofs  = 12'(val);
      CFG_RIGHT_OFFSET: right_ofs = 12'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(int kp, int kd, int hov, int smax,
                           int fo, int bo, int lo, int ro);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_HOVER_SPEED, hov);
    write_reg(CFG_SPEED_MAX, smax);
    write_reg(CFG_FRONT_OFFSET, fo);
    write_reg(CFG_BACK_OFFSET, bo);
    write_reg(CFG_LEFT_OFFSET, lo);
    write_reg(CFG_RIGHT_OFFSET, ro);
    cfg_phases++;
  endtask

  function automatic int pick_value(int lo, int hi);
    case ($urandom_range(5, 0))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic test_reset_config();
    send_sample(16'sd0, 16'sd0, 12'sd0, 12'sd0);
    send_sample(16'sd32767, 16'sd32767, 12'sd2047, 12'sd2047);
    send_sample(-16'sd32768, -16'sd32768, -12'sd2048, -12'sd2048);
    send_sample(16'sd1000, -16'sd2000, 12'sd681, 12'sd682);
    send_sample(-16'sd300, 16'sd450, 12'sd680, -12'sd1);
    drain();
  endtask

  // gain of 8.0 so that odd angles land exactly on the rounding tie
  task automatic test_rounding_ties();
    write_all(2048, 0, 500, 1023, 100, 200, 300, 400);
    send_sample(16'sd1, 16'sd0, 12'sd1, 12'sd0);
    send_sample(-16'sd1, 16'sd0, 12'sd0, 12'sd1);
    send_sample(16'sd3, 16'sd0, 12'sd1023, 12'sd1024);
    send_sample(-16'sd3, 16'sd0, 12'sd1022, -12'sd2);
    drain();
  endtask

  task automatic test_duty_saturation();
    write_all(65535, 65535, 1023, 1023, 4095, 4095, 4095, 4095);
    send_sample(16'sd0, 16'sd0, 12'sd2047, 12'sd2047);
    send_sample(16'sd0, 16'sd0, 12'sd0, -12'sd5);
    send_sample(-16'sd1, 16'sd1, 12'sd1, 12'sd512);
    drain();
  endtask

  task automatic test_zero_speed_max();
    write_all(30196, 3020, 471, 0, 827, 891, 886, 890);
    send_sample(16'sd32767, 16'sd0, 12'sd2047, -12'sd2048);
    send_sample(-16'sd32768, 16'sd32767, 12'sd1, 12'sd100);
    send_sample(16'sd0, 16'sd0, 12'sd0, 12'sd0);
    drain();
  endtask

  task automatic send_random_sample();
    logic signed [15:0] a;
    logic signed [15:0] r;
    logic signed [11:0] l;
    logic signed [11:0] rt;
    // each field is drawn near level flight in half of the draws so front and back stay in range
    a  = $urandom_range(1, 0) ? 16'($urandom) : 16'(int'($urandom_range(8192, 0)) - 4096);
    r  = $urandom_range(1, 0) ? 16'($urandom) : 16'(int'($urandom_range(8192, 0)) - 4096);
    l  = $urandom_range(1, 0) ? 12'($urandom) : 12'(int'($urandom_range(1200, 0)) - 64);
    rt = $urandom_range(1, 0) ? 12'($urandom) : 12'(int'($urandom_range(1200, 0)) - 64);
    send_sample(a, r, l, rt);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)
        write_all(65535, 65535, 1023, 1023, 4095, 4095, 4095, 4095);
      else if (ph == 1)
        write_all(0, 0, 0, 1, 0, 0, 0, 0);
      else
        write_all(pick_value(0, 65535), pick_value(0, 65535), pick_value(0, 1023),
                  pick_value(1, 1023), pick_value(0, 4095), pick_value(0, 4095),
                  pick_value(0, 4095), pick_value(0, 4095));
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (i % 25 == 0) idle_on = ($urandom_range(3, 0) != 0);
        send_random_sample();
      end
      drain();
    end
  endtask

  initial begin : main
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    kp_reg    = 16'd30196;
    kd_reg    = 16'd3020;
    hover_reg = 10'd471;
    smax_reg  = 10'd681;
    front_ofs = 12'd827;
    back_ofs  = 12'd891;
    left_ofs  = 12'd886;
    right_ofs = 12'd890;
    samples_sent = 0;
    duties_seen  = 0;
    mismatches   = 0;
    cfg_phases   = 1;
    idle_on      = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_rounding_ties();
    test_duty_saturation();
    test_zero_speed_max();
    test_random_settings();

    drain();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    $display("covered %0d samples, %0d duty words, %0d register settings",
             samples_sent, duties_seen, cfg_phases);
    $display("mismatching fields or words: %0d, words still owed: %0d",
             mismatches, duty_q.size());
    if (mismatches == 0 && duty_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
